/* src/ilgs_pkg.sv */
// Package for the illuminance Gauss-Seidel update block: widths and pipeline
// latencies for every module, and the channel-sum helper of the top level.
// Depends on nothing.
package ilgs_pkg;

   localparam int FRAC_BITS = 16;               // fraction bits of levels and gain
   localparam int WFRAC     = 16;               // fraction bits of a weight (Q16.16)
   localparam int PIX_W     = 24;
   localparam int LVL_W     = 24;
   localparam int SMOOTH_W  = 24;
   localparam int MIN_W     = 16;
   localparam int LANES     = 4;
   localparam int SUM_W     = 10;               // R+G+B, at most 765
   localparam int INT_SCALE = 765;
   localparam int WNUM_W    = SUM_W + WFRAC;    // weight divider operands
   localparam int W_W       = 32;               // Q16.16 weight
   localparam int LW_W      = LVL_W + W_W + 2;  // sum of four level*weight
   localparam int WSUM_W    = W_W + 2;          // sum of four weights
   localparam int S3_W      = SMOOTH_W + 2;     // three times the gain
   localparam int LWH_W     = LW_W / 2;
   localparam int WSH_W     = WSUM_W / 2;
   localparam int PL_W      = S3_W + LWH_W;
   localparam int PD_W      = S3_W + WSH_W;
   localparam int BASE_SH   = 2 * FRAC_BITS + 16;
   localparam int NUM_W     = BASE_SH + SUM_W + 28;
   localparam int DEN_W     = BASE_SH + 14;
   localparam int R0_W      = NUM_W + FRAC_BITS - LVL_W;

   localparam int WDIV_LAT  = W_W + 1;
   localparam int LDIV_LAT  = LVL_W + 1;
   localparam int C_IDX     = 2 + WDIV_LAT;
   localparam int F_IDX     = C_IDX + 3;
   localparam int PIPE_LAT  = F_IDX + LDIV_LAT + 2;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_SMOOTHNESS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_LEVEL  = 2'd1;

   localparam logic [SMOOTH_W-1:0] SMOOTH_RESET = 24'd65536;
   localparam logic [MIN_W-1:0]    MIN_RESET    = 16'd6554;

   function automatic logic [SUM_W-1:0] chan_sum(input logic [PIX_W-1:0] p);
      chan_sum = SUM_W'(p[23:16]) + SUM_W'(p[15:8]) + SUM_W'(p[7:0]);
   endfunction

endpackage

/* src/ilgs_weight_div.sv */
// Pipelined restoring divider for one Q16.16 neighbour weight, one quotient
// bit per stage, saturating at all ones. Depends on ilgs_pkg.
module ilgs_weight_div (
   input  logic                         clock,
   input  logic [ilgs_pkg::WNUM_W-1:0]  num,
   input  logic [ilgs_pkg::WNUM_W-1:0]  den,
   output logic [ilgs_pkg::W_W-1:0]     weight
);
   import ilgs_pkg::*;

   localparam int STEPS = W_W;
   localparam int TOP_W = WNUM_W + WFRAC - W_W;

   logic [WNUM_W-1:0] rem_ff [0:STEPS];
   logic [WNUM_W-1:0] den_ff [0:STEPS];
   logic [W_W-1:0]    dvd_ff [0:STEPS];
   logic [W_W-1:0]    quo_ff [0:STEPS];
   logic              sat_ff [0:STEPS];

   logic [WNUM_W+WFRAC-1:0] wide;
   logic [TOP_W-1:0]        top;
   logic                    sat_in;

   assign wide   = {num, WFRAC'(0)};
   assign top    = wide[WNUM_W+WFRAC-1:W_W];
   assign sat_in = WNUM_W'(top) >= den;

   always_ff @(posedge clock) begin
      rem_ff[0] <= sat_in ? '0 : WNUM_W'(top);
      den_ff[0] <= den;
      dvd_ff[0] <= wide[W_W-1:0];
      quo_ff[0] <= '0;
      sat_ff[0] <= sat_in;
   end

   for (genvar j = 0; j < STEPS; j++) begin : g_step
      logic [WNUM_W:0] trial;
      logic [WNUM_W:0] diff;
      logic            ge;
      always_comb begin
         trial = {rem_ff[j], dvd_ff[j][W_W-1]};
         diff  = trial - {1'b0, den_ff[j]};
         ge    = trial >= {1'b0, den_ff[j]};
      end
      always_ff @(posedge clock) begin
         rem_ff[j+1] <= ge ? diff[WNUM_W-1:0] : trial[WNUM_W-1:0];
         den_ff[j+1] <= den_ff[j];
         dvd_ff[j+1] <= {dvd_ff[j][W_W-2:0], 1'b0};
         quo_ff[j+1] <= {quo_ff[j][W_W-2:0], ge};
         sat_ff[j+1] <= sat_ff[j];
      end
   end

   assign weight = sat_ff[STEPS] ? '1 : quo_ff[STEPS];

endmodule

/* src/ilgs_level_div.sv */
// Pipelined restoring divider for the updated level, one quotient bit per
// stage, saturating to the top of the Q8.16 range. Depends on ilgs_pkg.
module ilgs_level_div (
   input  logic                        clock,
   input  logic [ilgs_pkg::NUM_W-1:0]  num,
   input  logic [ilgs_pkg::DEN_W-1:0]  den,
   output logic [ilgs_pkg::LVL_W-1:0]  level
);
   import ilgs_pkg::*;

   localparam int STEPS = LVL_W;

   logic [DEN_W-1:0] rem_ff [0:STEPS];
   logic [DEN_W-1:0] den_ff [0:STEPS];
   logic [LVL_W-1:0] dvd_ff [0:STEPS];
   logic [LVL_W-1:0] quo_ff [0:STEPS];
   logic             sat_ff [0:STEPS];

   logic [NUM_W+FRAC_BITS-1:0] wide;
   logic [R0_W-1:0]            r0;
   logic                       sat_in;

   assign wide   = {num, FRAC_BITS'(0)};
   assign r0     = wide[NUM_W+FRAC_BITS-1:LVL_W];
   assign sat_in = r0 >= R0_W'(den);

   always_ff @(posedge clock) begin
      rem_ff[0] <= sat_in ? '0 : r0[DEN_W-1:0];
      den_ff[0] <= den;
      dvd_ff[0] <= wide[LVL_W-1:0];
      quo_ff[0] <= '0;
      sat_ff[0] <= sat_in;
   end

   for (genvar j = 0; j < STEPS; j++) begin : g_step
      logic [DEN_W:0] trial;
      logic [DEN_W:0] diff;
      logic           ge;
      always_comb begin
         trial = {rem_ff[j], dvd_ff[j][LVL_W-1]};
         diff  = trial - {1'b0, den_ff[j]};
         ge    = trial >= {1'b0, den_ff[j]};
      end
      always_ff @(posedge clock) begin
         rem_ff[j+1] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         den_ff[j+1] <= den_ff[j];
         dvd_ff[j+1] <= {dvd_ff[j][LVL_W-2:0], 1'b0};
         quo_ff[j+1] <= {quo_ff[j][LVL_W-2:0], ge};
         sat_ff[j+1] <= sat_ff[j];
      end
   end

   assign level = sat_ff[STEPS] ? '1 : quo_ff[STEPS];

endmodule

/* src/illuminance_gauss_seidel_update_top.sv */
// Top level of the illuminance Gauss-Seidel pixel update pipeline.
// Depends on ilgs_pkg, ilgs_weight_div and ilgs_level_div.
//
// Usage:
//   Input channel: drive the req_ fields and raise start; the word is taken
//   at each rising edge where start is high and busy is low. busy is high
//   only in the cycle after reset, so one word may enter every clock.
//   Result channel: rsp_valid strobes for exactly one cycle with
//   rsp_new_level; the receiver cannot stall, so capture it in that cycle.
//   Results leave in the order the words entered.
//   Throughput: one word per cycle, set by the fully pipelined weight
//   dividers (33 stages: a load stage, then one quotient bit each) and
//   the level divider (25 stages).
//   Configuration: csr_valid/csr_ready write csr_data into the register
//   selected by csr_index (0 smoothness, 1 min_level; other indexes are
//   dropped). csr_ready is always high. Write only while the pipeline is
//   empty. A min_level of zero acts as one.
//   Reset: synchronous, active high; clears all valid bits and restores the
//   register defaults. Words in flight are dropped.
module illuminance_gauss_seidel_update_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [ilgs_pkg::PIX_W-1:0]     req_center_pixel,
   input  logic [ilgs_pkg::PIX_W-1:0]     req_up_pixel,
   input  logic [ilgs_pkg::PIX_W-1:0]     req_down_pixel,
   input  logic [ilgs_pkg::PIX_W-1:0]     req_left_pixel,
   input  logic [ilgs_pkg::PIX_W-1:0]     req_right_pixel,
   input  logic [ilgs_pkg::LVL_W-1:0]     req_up_level,
   input  logic [ilgs_pkg::LVL_W-1:0]     req_down_level,
   input  logic [ilgs_pkg::LVL_W-1:0]     req_left_level,
   input  logic [ilgs_pkg::LVL_W-1:0]     req_right_level,
   input  logic [ilgs_pkg::LANES-1:0]     req_neighbor_present,
   output logic                           rsp_valid,
   output logic [ilgs_pkg::LVL_W-1:0]     rsp_new_level,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [ilgs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ilgs_pkg::SMOOTH_W-1:0]  csr_data
);
   import ilgs_pkg::*;

   // Side data that rides alongside the weight dividers.
   typedef struct packed {
      logic [LANES-1:0][LVL_W-1:0] levels;
      logic [LANES-1:0]            mask;
      logic [SUM_W-1:0]            sc;
   } carry_type;

   localparam logic [DEN_W-1:0] DEN_MIN = DEN_W'(3) << BASE_SH;

   // Control and configuration
   logic                busy_ff;
   logic [SMOOTH_W-1:0] smooth_ff;
   logic [MIN_W-1:0]    min_ff;
   logic                vld_ff [0:PIPE_LAT-1];
   logic                accept;

   assign accept    = start && !busy_ff;
   assign busy      = busy_ff;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b1;
         smooth_ff <= SMOOTH_RESET;
         min_ff    <= MIN_RESET;
      end else begin
         busy_ff <= 1'b0;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_SMOOTHNESS: smooth_ff <= csr_data;
               CSR_MIN_LEVEL:  min_ff    <= csr_data[MIN_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // Valid bits travel one stage per clock alongside the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PIPE_LAT; i++) vld_ff[i] <= 1'b0;
      end else begin
         vld_ff[0] <= accept;
         for (int i = 1; i < PIPE_LAT; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   // Stage A: intensity sums of all five pixels.
   logic [SUM_W-1:0]            a_sc_ff;
   logic [LANES-1:0][SUM_W-1:0] a_sk_ff;
   carry_type                   a_car_ff;

   always_ff @(posedge clock) begin
      a_sc_ff         <= chan_sum(req_center_pixel);
      a_sk_ff         <= {chan_sum(req_right_pixel), chan_sum(req_left_pixel),
                          chan_sum(req_down_pixel), chan_sum(req_up_pixel)};
      a_car_ff.levels <= {req_right_level, req_left_level, req_down_level, req_up_level};
      a_car_ff.mask   <= req_neighbor_present;
      a_car_ff.sc     <= chan_sum(req_center_pixel);
   end

   // Stage B: clamp the weight numerator and denominator to the floor.
   logic [MIN_W-1:0]            m_eff;
   logic [WNUM_W-1:0]           floor_lvl;
   logic [WNUM_W-1:0]           b_num_ff [0:LANES-1];
   logic [WNUM_W-1:0]           b_den_ff [0:LANES-1];
   carry_type                   b_car_ff;

   assign m_eff     = (min_ff == '0) ? MIN_W'(1) : min_ff;
   assign floor_lvl = WNUM_W'(m_eff) * WNUM_W'(INT_SCALE);

   for (genvar k = 0; k < LANES; k++) begin : g_lane_b
      logic [SUM_W-1:0]  lo;
      logic [SUM_W-1:0]  df;
      logic [WNUM_W-1:0] nv;
      logic [WNUM_W-1:0] dv;
      always_comb begin
         lo = (a_sk_ff[k] < a_sc_ff) ? a_sk_ff[k] : a_sc_ff;
         df = (a_sk_ff[k] < a_sc_ff) ? a_sc_ff - a_sk_ff[k] : a_sk_ff[k] - a_sc_ff;
         nv = {lo, WFRAC'(0)};
         dv = {df, WFRAC'(0)};
      end
      always_ff @(posedge clock) begin
         b_num_ff[k] <= (nv < floor_lvl) ? floor_lvl : nv;
         b_den_ff[k] <= (dv < floor_lvl) ? floor_lvl : dv;
      end
   end

   always_ff @(posedge clock) begin
      b_car_ff <= a_car_ff;
   end

   // Weight dividers, one per neighbour, with the side data delayed to match.
   logic [W_W-1:0] weight [0:LANES-1];
   carry_type      dly_ff [0:WDIV_LAT-1];

   for (genvar k = 0; k < LANES; k++) begin : g_wdiv
      ilgs_weight_div u_wdiv (
         .clock  (clock),
         .num    (b_num_ff[k]),
         .den    (b_den_ff[k]),
         .weight (weight[k])
      );
   end

   always_ff @(posedge clock) begin
      dly_ff[0] <= b_car_ff;
      for (int i = 1; i < WDIV_LAT; i++) dly_ff[i] <= dly_ff[i-1];
   end

   // Stage C: drop absent neighbours, form level times weight.
   logic [W_W-1:0]         c_w_ff  [0:LANES-1];
   logic [LVL_W+W_W-1:0]   c_lw_ff [0:LANES-1];
   logic [SUM_W-1:0]       c_sc_ff;

   for (genvar k = 0; k < LANES; k++) begin : g_lane_c
      logic [W_W-1:0] w_eff;
      assign w_eff = dly_ff[WDIV_LAT-1].mask[k] ? weight[k] : '0;
      always_ff @(posedge clock) begin
         c_w_ff[k]  <= w_eff;
         c_lw_ff[k] <= (LVL_W+W_W)'(dly_ff[WDIV_LAT-1].levels[k]) * (LVL_W+W_W)'(w_eff);
      end
   end

   always_ff @(posedge clock) begin
      c_sc_ff <= dly_ff[WDIV_LAT-1].sc;
   end

   // Stage D: sum across the four lanes.
   logic [LW_W-1:0]   d_lw_ff;
   logic [WSUM_W-1:0] d_ws_ff;
   logic [SUM_W-1:0]  d_sc_ff;

   always_ff @(posedge clock) begin
      d_lw_ff <= LW_W'(c_lw_ff[0]) + LW_W'(c_lw_ff[1]) + LW_W'(c_lw_ff[2]) + LW_W'(c_lw_ff[3]);
      d_ws_ff <= WSUM_W'(c_w_ff[0]) + WSUM_W'(c_w_ff[1]) + WSUM_W'(c_w_ff[2])
               + WSUM_W'(c_w_ff[3]);
      d_sc_ff <= c_sc_ff;
   end

   // Stage E: scale by three times the gain, split into halves.
   logic [S3_W-1:0]  s3;
   logic [PL_W-1:0]  e_plo_ff;
   logic [PL_W-1:0]  e_phi_ff;
   logic [PD_W-1:0]  e_dlo_ff;
   logic [PD_W-1:0]  e_dhi_ff;
   logic [SUM_W-1:0] e_sc_ff;

   assign s3 = S3_W'(smooth_ff) * S3_W'(3);

   always_ff @(posedge clock) begin
      e_plo_ff <= PL_W'(s3) * PL_W'(d_lw_ff[LWH_W-1:0]);
      e_phi_ff <= PL_W'(s3) * PL_W'(d_lw_ff[LW_W-1:LWH_W]);
      e_dlo_ff <= PD_W'(s3) * PD_W'(d_ws_ff[WSH_W-1:0]);
      e_dhi_ff <= PD_W'(s3) * PD_W'(d_ws_ff[WSUM_W-1:WSH_W]);
      e_sc_ff  <= d_sc_ff;
   end

   // Stage F: assemble the exact numerator and denominator.
   logic [NUM_W-1:0] f_num_ff;
   logic [DEN_W-1:0] f_den_ff;

   always_ff @(posedge clock) begin
      f_num_ff <= (NUM_W'(e_sc_ff) << BASE_SH) + (NUM_W'(e_phi_ff) << LWH_W)
                + NUM_W'(e_plo_ff);
      f_den_ff <= DEN_MIN + (DEN_W'(e_dhi_ff) << WSH_W) + DEN_W'(e_dlo_ff);
   end

   // Final division and output register.
   logic [LVL_W-1:0] quot;
   logic [LVL_W-1:0] rsp_level_ff;

   ilgs_level_div u_ldiv (
      .clock (clock),
      .num   (f_num_ff),
      .den   (f_den_ff),
      .level (quot)
   );

   always_ff @(posedge clock) begin
      rsp_level_ff <= quot;
   end

   assign rsp_valid     = vld_ff[PIPE_LAT-1];
   assign rsp_new_level = rsp_level_ff;

   // Every accepted word leaves after the fixed latency.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##PIPE_LAT rsp_valid)
      else $error("accepted word did not emerge after pipeline latency");

   // The denominator never drops below its constant term.
   a_den_floor: assert property (@(posedge clock) disable iff (reset)
      vld_ff[F_IDX] |-> f_den_ff >= DEN_MIN)
      else $error("level divider denominator below its floor");

   // Input is held off in the cycle after reset.
   a_busy_reset: assert property (@(posedge clock)
      reset |=> busy)
      else $error("busy low straight after reset");

   // An absent up neighbour (lane 0) carries no weight into the sums.
   a_mask_zero: assert property (@(posedge clock) disable iff (reset)
      vld_ff[C_IDX-1] && !dly_ff[WDIV_LAT-1].mask[0] |=> c_w_ff[0] == '0)
      else $error("absent neighbour kept a weight");

endmodule

/* sim/tb_illuminance_gauss_seidel_update_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for the illuminance Gauss-Seidel pixel update pipeline.
// Depends on ilgs_pkg and illuminance_gauss_seidel_update_top.
module tb_illuminance_gauss_seidel_update_top;
   import ilgs_pkg::*;

   // Register indexes with no register behind them.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

   // One neighbourhood word as the block takes it.
   typedef struct {
      logic [PIX_W-1:0]            center;
      logic [LANES-1:0][PIX_W-1:0] nb_pix;   // up, down, left, right
      logic [LANES-1:0][LVL_W-1:0] nb_lvl;
      logic [LANES-1:0]            present;
   } hood_type;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   hood_type              drv;
   logic                  rsp_valid;
   logic [LVL_W-1:0]      rsp_new_level;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [SMOOTH_W-1:0]   csr_data;

   // Shadow copies of the two registers, used by the predictor.
   logic [SMOOTH_W-1:0]   gain_shadow;
   logic [MIN_W-1:0]      floor_shadow;

   logic [LVL_W-1:0]      level_queue[$];
   int                    mismatches;
   int                    words_sent;
   int                    levels_checked;
   int                    gap_pct;

   illuminance_gauss_seidel_update_top u_dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_center_pixel     (drv.center),
      .req_up_pixel         (drv.nb_pix[0]),
      .req_down_pixel       (drv.nb_pix[1]),
      .req_left_pixel       (drv.nb_pix[2]),
      .req_right_pixel      (drv.nb_pix[3]),
      .req_up_level         (drv.nb_lvl[0]),
      .req_down_level       (drv.nb_lvl[1]),
      .req_left_level       (drv.nb_lvl[2]),
      .req_right_level      (drv.nb_lvl[3]),
      .req_neighbor_present (drv.present),
      .rsp_valid            (rsp_valid),
      .rsp_new_level        (rsp_new_level),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Generous cap for roughly 1100 words with gaps.
   initial begin
      #4ms;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic logic [9:0] rgb_sum(logic [PIX_W-1:0] p);
      return 10'(p[23:16]) + 10'(p[15:8]) + 10'(p[7:0]);
   endfunction

   // Predict the updated level for one neighbourhood under the shadow registers.
   function automatic logic [LVL_W-1:0] predict_level(hood_type h);
      logic [63:0]  flr;
      logic [63:0]  lo_sum;
      logic [63:0]  diff;
      logic [63:0]  wn;
      logic [63:0]  wd;
      logic [63:0]  wt;
      logic [9:0]   sc;
      logic [9:0]   sk;
      logic [127:0] lw;
      logic [127:0] wsum;
      logic [127:0] gain3;
      logic [127:0] num;
      logic [127:0] den;
      logic [127:0] quo;
      sc    = rgb_sum(h.center);
      flr   = 64'(floor_shadow == 0 ? 16'd1 : floor_shadow) * 765;
      gain3 = 128'(gain_shadow) * 3;
      lw    = '0;
      wsum  = '0;
      for (int k = 0; k < LANES; k++) begin
         if (h.present[k]) begin
            sk     = rgb_sum(h.nb_pix[k]);
            lo_sum = 64'(sk < sc ? sk : sc);
            diff   = 64'(sk < sc ? sc - sk : sk - sc);
            wn     = lo_sum << 16;
            wd     = diff << 16;
            if (wn < flr) wn = flr;
            if (wd < flr) wd = flr;
            wt     = (wn << 16) / wd;
            if (wt > 64'hFFFF_FFFF) wt = 64'hFFFF_FFFF;   // weight saturates
            lw     = lw + 128'(h.nb_lvl[k]) * 128'(wt);
            wsum   = wsum + 128'(wt);
         end
      end
      num = (128'(sc) << BASE_SH) + gain3 * lw;
      den = (128'd3 << BASE_SH) + gain3 * wsum;
      quo = (num << FRAC_BITS) / den;
      return (quo > 128'hFF_FFFF) ? 24'hFF_FFFF : quo[LVL_W-1:0];
   endfunction

   task automatic report_mismatch(string what, logic [LVL_W-1:0] got, logic [LVL_W-1:0] want);
      mismatches++;
      $display("t=%0t mismatch %s: got %h want %h", $time, what, got, want);
   endtask

   // Check every level word against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (level_queue.size() == 0) begin
            report_mismatch("unexpected level", rsp_new_level, '0);
         end else begin
            if (rsp_new_level !== level_queue[0])
               report_mismatch("new_level", rsp_new_level, level_queue[0]);
            void'(level_queue.pop_front());
            levels_checked++;
         end
      end
   end

   // Drive one word from the falling edge and hold it until taken; start stays
   // high afterwards so back-to-back words need no second assignment.
   task automatic send_word(hood_type h);
      @(negedge clock);
      drv   = h;
      start = 1'b1;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      level_queue.push_back(predict_level(h));
      words_sent++;
   endtask

   // Drop start for single idle cycles, each with the current gap percentage.
   task automatic maybe_gap();
      while ($urandom_range(99) < gap_pct) begin
         @(negedge clock);
         start = 1'b0;
      end
   endtask

   // Hold off until the pipeline has drained, then let the latency pass.
   task automatic drain();
      @(negedge clock);
      start = 1'b0;
      while (level_queue.size() != 0) @(negedge clock);
      repeat (PIPE_LAT + 4) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [SMOOTH_W-1:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = data;
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      case (idx)
         CSR_SMOOTHNESS: gain_shadow  = data;
         CSR_MIN_LEVEL:  floor_shadow = data[MIN_W-1:0];
         default: ;      // unknown index: drop
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic logic [PIX_W-1:0] grey(logic [7:0] v);
      return {v, v, v};
   endfunction

   // Random neighbourhood; often near-equal pixels so the weight denominators
   // hit the floor, sometimes fully random.
   function automatic hood_type random_hood();
      hood_type h;
      h.center  = 24'($urandom());
      h.present = 4'($urandom());
      for (int k = 0; k < LANES; k++) begin
         case ($urandom_range(3))
            0: h.nb_pix[k] = h.center;
            1: h.nb_pix[k] = h.center ^ (24'h1 << $urandom_range(23));
            default: h.nb_pix[k] = 24'($urandom());
         endcase
         h.nb_lvl[k] = ($urandom_range(3) == 0) ? 24'($urandom_range(255) << 16)
                                                : 24'($urandom());
      end
      return h;
   endfunction

   task automatic test_directed();
      hood_type h;
      // no neighbours: level is the centre intensity alone
      h.nb_pix = '0; h.nb_lvl = '0; h.present = '0;
      h.center = 24'hFFFFFF;                         send_word(h);
      h.center = '0;                                 send_word(h);
      h.center = 24'h123456;                         send_word(h);
      // every mask pattern with equal pixels (denominator at the floor) and max levels
      for (int p = 0; p < 16; p++) begin
         h.center  = grey(8'd200);
         h.nb_pix  = {4{grey(8'd200)}};
         h.nb_lvl  = {4{24'hFFFFFF}};
         h.present = 4'(p);
         send_word(h);
      end
      // black centre against white neighbours: lowest weight
      h.center = '0; h.nb_pix = {4{24'hFFFFFF}}; h.present = 4'hF;
      h.nb_lvl = {24'h000000, 24'hFFFFFF, 24'h800000, 24'h000001};
      send_word(h);
      // white centre, black neighbours, zero levels
      h.center = 24'hFFFFFF; h.nb_pix = '0; h.nb_lvl = '0;
      send_word(h);
      // alternating bit patterns on every field
      h.center = 24'hAAAAAA; h.nb_pix = {4{24'h555555}};
      h.nb_lvl = {4{24'hAAAAAA}}; h.present = 4'hA;
      send_word(h);
      h.center = 24'h555555; h.nb_pix = {4{24'hAAAAAA}};
      h.nb_lvl = {4{24'h555555}}; h.present = 4'h5;
      send_word(h);
      drain();
   endtask

   task automatic test_random(int count);
      for (int i = 0; i < count; i++) begin
         send_word(random_hood());
         maybe_gap();
         // once in a while pause until everything is back
         if (i % 97 == 50) drain();
      end
      drain();
   endtask

   // Walk the register settings, extremes included, with traffic at each.
   task automatic test_register_sweep();
      logic [SMOOTH_W-1:0] gains[5]  = '{24'd0, 24'hFFFFFF, 24'd1, 24'd65536, 24'h0C0000};
      logic [MIN_W-1:0]    floors[5] = '{16'd0, 16'd1, 16'hFFFF, 16'd6554, 16'd300};
      for (int i = 0; i < 5; i++) begin
         write_csr(CSR_SMOOTHNESS, gains[i]);
         write_csr(CSR_MIN_LEVEL, 24'(floors[i]));
         test_random(30);
      end
      // writes to unused indexes must leave both registers alone
      write_csr(CSR_SPARE_A, 24'h000123);
      write_csr(CSR_SPARE_B, 24'hFFFFFF);
      test_random(20);
      for (int i = 0; i < 4; i++) begin
         write_csr(CSR_SMOOTHNESS, 24'($urandom()));
         write_csr(CSR_MIN_LEVEL, 24'($urandom()));
         test_random(40);
      end
      write_csr(CSR_SMOOTHNESS, SMOOTH_RESET);
      write_csr(CSR_MIN_LEVEL, 24'(MIN_RESET));
   endtask

   initial begin
      mismatches = 0; words_sent = 0; levels_checked = 0; gap_pct = 0;
      reset = 1'b1; start = 1'b0; csr_valid = 1'b0; csr_index = '0; csr_data = '0;
      drv.center = '0; drv.nb_pix = '0; drv.nb_lvl = '0; drv.present = '0;
      gain_shadow = SMOOTH_RESET;
      floor_shadow = MIN_RESET;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      gap_pct = 29;
      test_random(300);
      test_register_sweep();
      gap_pct = 45;
      test_random(200);
      gap_pct = 0;
      test_random(220);

      $display("covered %0d neighbourhood words, %0d levels checked,", words_sent,
               levels_checked);
      $display("all mask patterns, register extremes and unused register indexes");
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
